// ----- rtl/ate_pkg.sv -----
package ate_pkg;

    localparam int CAP_DEFAULT = 64;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 6;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_MODIFY = 2'd1,
        OP_APPEND = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // source of the old_value field of a result
    typedef enum logic [1:0] {
        OLD_ZERO  = 2'd0,
        OLD_RDATA = 2'd1,
        OLD_HELD  = 2'd2
    } t_old_sel;

    typedef struct packed {
        logic     load;      // latch the transaction operands
        logic     rd_index;  // read the entry at the operand index
        logic     wr_index;  // write the operand value at the operand index
        logic     append;    // write the operand value past the end, count up
        logic     scan;      // read at the scan pointer if it is below the count
        logic     shift_wr;  // write the scanned entry one place down
        logic     ptr_skip;  // scan pointer to operand index plus one
        logic     cap_old;   // hold the read data as the old value
        logic     count_dec; // one entry fewer
        logic     emit;      // load the result registers
        t_status  status;
        logic     pos_hit;   // report the compared position
        t_old_sel old_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_ok;  // operand index below the live count
        logic full;
        logic ptr_lt;  // scan pointer below the live count
        logic rd_vld;  // read data holds a scanned entry
        logic match;   // read data equals the operand value
    } t_dp_stat;

endpackage

// ----- rtl/ate_datapath.sv -----
module ate_datapath #(
    parameter int CAPACITY = ate_pkg::CAP_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ate_pkg::t_dp_cmd                    i_cmd,
    output ate_pkg::t_dp_stat                   o_stat,
    input  logic [ate_pkg::OP_W-1:0]            i_op,
    input  logic [ate_pkg::INDEX_W-1:0]         i_index,
    input  logic signed [ate_pkg::DATA_W-1:0]   i_value,
    output logic [ate_pkg::STATUS_W-1:0]        o_status,
    output logic [ate_pkg::POS_W-1:0]           o_position,
    output logic signed [ate_pkg::DATA_W-1:0]   o_old_value,
    output logic [ate_pkg::COUNT_W-1:0]         o_count
);
    import ate_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IXW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int PW  = (AW > POS_W) ? AW : POS_W;
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [DATA_W-1:0] mem [CAPACITY];

    t_op               r_op;
    logic [INDEX_W-1:0] r_index;
    logic [DATA_W-1:0] r_value;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_ptr;
    logic [AW-1:0]     r_rd_idx;
    logic              r_rd_vld;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_old;
    t_status           r_status;
    logic [POS_W-1:0]  r_position;
    logic [DATA_W-1:0] r_old_value;
    logic [COUNT_W-1:0] r_count_out;

    logic [IXW-1:0]    ext_index;
    logic [IXW-1:0]    ext_index_inc;
    logic              idx_ok;
    logic              ptr_lt;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [PW-1:0]     pos_ext;
    logic [CXW-1:0]    cnt_ext;
    logic [DATA_W-1:0] old_mux;

    assign ext_index     = IXW'(r_index);
    assign ext_index_inc = ext_index + IXW'(1);
    assign idx_ok        = ext_index < IXW'(r_count);
    assign ptr_lt        = r_ptr < r_count;

    assign rd_en   = i_cmd.rd_index | (i_cmd.scan & ptr_lt);
    assign rd_addr = i_cmd.rd_index ? ext_index[AW-1:0] : r_ptr[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ext_index[AW-1:0];
        wr_data = r_value;
        priority if (i_cmd.wr_index) begin
            wr_en = 1'b1;
        end else if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
        end else if (i_cmd.shift_wr && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx - AW'(1);
            wr_data = r_rdata;
        end
    end

    always_comb begin
        priority if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        unique case (i_cmd.old_sel)
            OLD_RDATA: old_mux = r_rdata;
            OLD_HELD:  old_mux = r_old;
            default:   old_mux = '0;
        endcase
    end

    assign pos_ext = PW'(r_rd_idx);
    assign cnt_ext = CXW'(n_count);

    // table storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                if (i_cmd.ptr_skip) begin
                    r_ptr <= ext_index_inc[CW-1:0];
                end else if (i_cmd.scan && ptr_lt) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                r_rd_vld <= i_cmd.scan & ptr_lt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_index <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.scan && ptr_lt) begin
            r_rd_idx <= r_ptr[AW-1:0];
        end
        if (i_cmd.cap_old) begin
            r_old <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_status    <= i_cmd.status;
            r_position  <= i_cmd.pos_hit ? pos_ext[POS_W-1:0] : '0;
            r_old_value <= old_mux;
            r_count_out <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign o_stat.op     = r_op;
    assign o_stat.idx_ok = idx_ok;
    assign o_stat.full   = r_count == CW'(CAPACITY);
    assign o_stat.ptr_lt = ptr_lt;
    assign o_stat.rd_vld = r_rd_vld;
    assign o_stat.match  = r_rdata == r_value;

    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_old_value = r_old_value;
    assign o_count     = r_count_out;

endmodule

// ----- rtl/ate_ctrl.sv -----
module ate_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ate_pkg::t_dp_stat i_stat,
    output ate_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import ate_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_MOD_OUT,
        S_RM_CAP,
        S_SHIFT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_FIND: begin
                        n_state = S_FIND;
                    end
                    OP_MODIFY: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_index = 1'b1;
                            o_cmd.wr_index = 1'b1;
                            n_state        = S_MOD_OUT;
                        end else begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_RANGE;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_APPEND: begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            o_cmd.status = ST_OK;
                        end
                    end
                    default: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_index = 1'b1;
                            o_cmd.ptr_skip = 1'b1;
                            n_state        = S_RM_CAP;
                        end else begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_RANGE;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_FIND: begin
                priority if (i_stat.rd_vld && i_stat.match) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.status  = ST_OK;
                    o_cmd.pos_hit = 1'b1;
                    n_state       = S_IDLE;
                end else if (!i_stat.ptr_lt && !i_stat.rd_vld) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_MOD_OUT: begin
                o_cmd.emit    = 1'b1;
                o_cmd.status  = ST_OK;
                o_cmd.old_sel = OLD_RDATA;
                n_state       = S_IDLE;
            end
            S_RM_CAP: begin
                o_cmd.cap_old = 1'b1;
                n_state       = S_SHIFT;
            end
            default: begin
                // read entry k, write it to k-1 in the next cycle
                o_cmd.scan     = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (!i_stat.ptr_lt && !i_stat.rd_vld) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.status    = ST_OK;
                    o_cmd.old_sel   = OLD_HELD;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.emit;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_valid;

endmodule

// ----- rtl/array_table_engine.sv -----
// Packed table of signed 32-bit entries with a live count.
// A transaction is taken at a rising edge where start is high and busy is
// low; i_op selects find, modify, append or remove, with i_index and i_value.
// Each transaction returns one result: o_valid is high for exactly one cycle
// with o_status, o_position, o_old_value and o_count (count after the op).
// The receiver cannot stall; a result is flagged valid for that one cycle only,
// and busy may already be low then, so the next transaction can be taken.
// Steps after the accepting edge, each op passing through dispatch first:
//   append, and any refused op: the result is emitted from dispatch
//   modify: read and write at the index, then the result
//   find: one entry compared per cycle until a match or the live count
//   remove: capture the old value, then one entry moved down per cycle
// Throughput is bounded by the table memory: one entry read and one entry
// written per cycle, so find and remove scale with the count.
// Reset (synchronous, active low) empties the table; entry contents are not
// cleared and are only read once written.
module array_table_engine #(
    parameter int CAPACITY = ate_pkg::CAP_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ate_pkg::OP_W-1:0]          i_op,
    input  logic [ate_pkg::INDEX_W-1:0]       i_index,
    input  logic signed [ate_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    output logic [ate_pkg::STATUS_W-1:0]      o_status,
    output logic [ate_pkg::POS_W-1:0]         o_position,
    output logic signed [ate_pkg::DATA_W-1:0] o_old_value,
    output logic [ate_pkg::COUNT_W-1:0]       o_count
);
    import ate_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ate_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ate_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_old_value (o_old_value),
        .o_count     (o_count)
    );

endmodule

// ----- tb/sv/array_table_engine_test.sv -----
`timescale 1ns / 1ps

module array_table_engine_test;
    import ate_pkg::*;

    localparam int CAP          = CAP_DEFAULT;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = CAP + 16;

    typedef struct {
        t_status                  status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] old_value;
        logic [COUNT_W-1:0]       count;
    } t_reply;

    // Shadow copy of the table; computes the reply each transaction should produce.
    class table_tracker;
        logic signed [DATA_W-1:0] entries [CAP];
        int                       live;
        t_reply                   pending [$];
        int                       mismatches;

        function void record_request(t_op op, logic [INDEX_W-1:0] idx,
                                     logic signed [DATA_W-1:0] val);
            t_reply r;
            r.status    = ST_OK;
            r.position  = '0;
            r.old_value = '0;
            case (op)
                OP_FIND: begin
                    r.status = ST_NOT_FOUND;
                    // scan downward so the lowest match is the one left
                    for (int i = live - 1; i >= 0; i--) begin
                        if (entries[i] == val) begin
                            r.status   = ST_OK;
                            r.position = POS_W'(i);
                        end
                    end
                end
                OP_MODIFY: begin
                    if (idx >= live) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.old_value  = entries[idx];
                        entries[idx] = val;
                    end
                end
                OP_APPEND: begin
                    if (live >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        entries[live] = val;
                        live++;
                    end
                end
                default: begin
                    if (idx >= live) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.old_value = entries[idx];
                        for (int i = idx; i < live - 1; i++) begin
                            entries[i] = entries[i + 1];
                        end
                        live--;
                    end
                end
            endcase
            r.count = COUNT_W'(live);
            pending.push_back(r);
        endfunction

        function void compare_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                $error("result with no transaction pending: status %0d count %0d",
                       got.status, got.count);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                mismatches++;
            end
            if (got.old_value !== want.old_value) begin
                $error("old_value: expected %0d, got %0d", want.old_value, got.old_value);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          i_op;
    logic [INDEX_W-1:0]       i_index;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [POS_W-1:0]         o_position;
    logic signed [DATA_W-1:0] o_old_value;
    logic [COUNT_W-1:0]       o_count;

    table_tracker tracker = new;
    bit           steady;

    array_table_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_index    (i_index),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_position (o_position),
        .o_old_value(o_old_value),
        .o_count    (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_valid) begin
            got.status    = t_status'(o_status);
            got.position  = o_position;
            got.old_value = o_old_value;
            got.count     = o_count;
            tracker.compare_reply(got);
        end
    end

    // Present one transaction; random idle cycles before it carry junk operands.
    task automatic issue_op(t_op op, logic [INDEX_W-1:0] idx,
                            logic signed [DATA_W-1:0] val);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 27) begin
            start   = 1'b0;
            i_op    = OP_W'($urandom_range(0, 3));
            i_index = INDEX_W'($urandom);
            i_value = $urandom;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_op    = op;
        i_index = idx;
        i_value = val;
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.record_request(op, idx, val);
    endtask

    initial begin
        t_op                      op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
        int                       phase;
        int                       roll;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_op    = OP_FIND;
        i_index = '0;
        i_value = '0;
        steady  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table refusals
        issue_op(OP_FIND,   0,  0);
        issue_op(OP_MODIFY, 0,  5);
        issue_op(OP_REMOVE, 63, 0);
        // extremes, with a duplicate
        issue_op(OP_APPEND, 0,  32'sh7FFFFFFF);
        issue_op(OP_APPEND, 63, 32'sh80000000);
        issue_op(OP_APPEND, 0,  0);
        issue_op(OP_APPEND, 0,  -1);
        issue_op(OP_APPEND, 0,  32'sh80000000);
        issue_op(OP_FIND,   0,  32'sh80000000);
        issue_op(OP_FIND,   0,  -1);
        issue_op(OP_FIND,   0,  32'sh7FFFFFFF);
        issue_op(OP_FIND,   0,  1);
        issue_op(OP_MODIFY, 0,  -1);
        issue_op(OP_FIND,   63, -1);
        // index equal to the count is out of range
        issue_op(OP_MODIFY, 5,  9);
        issue_op(OP_REMOVE, 5,  0);
        issue_op(OP_MODIFY, 4,  32'sh7FFFFFFF);
        issue_op(OP_REMOVE, 0,  0);
        issue_op(OP_REMOVE, 3,  0);
        issue_op(OP_REMOVE, 1,  0);
        issue_op(OP_FIND,   0,  32'sh80000000);
        issue_op(OP_REMOVE, 1,  0);
        issue_op(OP_REMOVE, 0,  0);
        issue_op(OP_FIND,   0,  -1);

        // phases, each run twice: grow (fills the table past full), churn, drain
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase  = (n / 125) % 3;
            steady = (n >= 400 && n < 550);
            roll   = $urandom_range(0, 99);
            if (phase == 0) begin
                if (roll < 70)      op = OP_APPEND;
                else if (roll < 80) op = OP_FIND;
                else if (roll < 90) op = OP_MODIFY;
                else                op = OP_REMOVE;
            end else if (phase == 1) begin
                op = t_op'(roll % 4);
            end else begin
                if (roll < 55)      op = OP_REMOVE;
                else if (roll < 75) op = OP_FIND;
                else if (roll < 90) op = OP_MODIFY;
                else                op = OP_APPEND;
            end

            if (tracker.live > 0 && $urandom_range(0, 99) < 80)
                idx = INDEX_W'($urandom_range(0, tracker.live - 1));
            else
                idx = INDEX_W'($urandom_range(0, 63));

            roll = $urandom_range(0, 99);
            if (roll < 40 && tracker.live > 0) begin
                val = tracker.entries[$urandom_range(0, tracker.live - 1)];
            end else if (roll < 70) begin
                // narrow pool so duplicates are common
                val = $urandom_range(0, 15) - 8;
            end else if (roll < 80) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'sh7FFFFFFF;
                    1:       val = 32'sh80000000;
                    2:       val = 0;
                    default: val = -1;
                endcase
            end else begin
                val = $urandom;
            end

            issue_op(op, idx, val);
        end

        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
